// File: hw/rtl/eq_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the Euler to quaternion block.
// No dependencies; imported by every module of the block.
package eq_pkg;

    localparam int XW = 33;   // CORDIC x/y, Q.30 with headroom
    localparam int ZW = 34;   // half angle / residual angle, Q.30
    localparam int SW = 32;   // sine/cosine and products, Q.30

    localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [XW-1:0] GAIN_Q30    = 33'sd652032874;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } lane_t;

    typedef struct packed {
        lane_t [2:0] lane;
        logic  [2:0] flip;
    } cordic_t;

    typedef struct packed {
        logic [2:0][SW-1:0] s;
        logic [2:0][SW-1:0] c;
    } trig_t;

    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0:       r = 34'sd843314856;
            1:       r = 34'sd497837829;
            2:       r = 34'sd263043836;
            3:       r = 34'sd133525158;
            4:       r = 34'sd67021686;
            5:       r = 34'sd33543515;
            6:       r = 34'sd16775850;
            7:       r = 34'sd8388437;
            8:       r = 34'sd4194282;
            9:       r = 34'sd2097149;
            default: r = (i < 30) ? ((34'sd1 <<< (30 - i)) - 34'sd1) : 34'sd0;
        endcase
        return r;
    endfunction

    // Exact product rounded to Q.30, floor of (a*b + half)
    function automatic logic signed [SW-1:0] qmul(input logic signed [SW-1:0] a,
                                                  input logic signed [SW-1:0] b);
        logic signed [2*SW-1:0] p;
        logic signed [2*SW-1:0] r;
        p = a * b;
        r = (p + (64'sd1 <<< 29)) >>> 30;
        return r[SW-1:0];
    endfunction

endpackage

// File: hw/rtl/eq_cordic_stage.sv
`timescale 1ns / 1ps
// One registered CORDIC rotation step applied to the three angle lanes.
// Depends on eq_pkg.
module eq_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            enable,
    input  logic            in_valid,
    input  eq_pkg::cordic_t in_data,
    output logic            out_valid,
    output eq_pkg::cordic_t out_data
);
    import eq_pkg::*;

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;

    always_comb begin
        data_next = in_data;
        for (int k = 0; k < 3; k++) begin
            if (in_data.lane[k].z >= 0) begin
                data_next.lane[k].x = in_data.lane[k].x - (in_data.lane[k].y >>> STEP);
                data_next.lane[k].y = in_data.lane[k].y + (in_data.lane[k].x >>> STEP);
                data_next.lane[k].z = in_data.lane[k].z - atan_q30(STEP);
            end else begin
                data_next.lane[k].x = in_data.lane[k].x + (in_data.lane[k].y >>> STEP);
                data_next.lane[k].y = in_data.lane[k].y - (in_data.lane[k].x >>> STEP);
                data_next.lane[k].z = in_data.lane[k].z + atan_q30(STEP);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (enable) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hw/rtl/eq_quat_mult.sv
`timescale 1ns / 1ps
// Quaternion product network: two multiply stages, then sum, round and saturate.
// Depends on eq_pkg.
module eq_quat_mult #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        enable,
    input  logic                        in_valid,
    input  eq_pkg::trig_t               trig,
    output logic                        out_valid,
    output logic [4*COMPONENT_BITS-1:0] quat   // w, x, y, z from lowest bit
);
    import eq_pkg::*;

    localparam int SH = 32 - COMPONENT_BITS;
    localparam logic signed [ZW-1:0] RND = (34'sd1 <<< SH) >>> 1;
    localparam logic signed [ZW-1:0] HI  = (34'sd1 <<< (COMPONENT_BITS - 1)) - 34'sd1;
    localparam logic signed [ZW-1:0] LO  = -HI - 34'sd1;

    logic signed [SW-1:0] sx, cx, sy, cy, sz, cz;

    logic                 v1_reg, v2_reg, v3_reg;
    logic signed [SW-1:0] p_reg, q_reg, cxsy_reg, sxcy_reg, cxcy_reg, sxsy_reg;
    logic signed [SW-1:0] cx1_reg, sx1_reg, cz1_reg, sz1_reg;
    logic signed [SW-1:0] t_reg [8];
    logic [4*COMPONENT_BITS-1:0] quat_reg;
    logic [4*COMPONENT_BITS-1:0] quat_next;

    assign sx = $signed(trig.s[0]);
    assign cx = $signed(trig.c[0]);
    assign sy = $signed(trig.s[1]);
    assign cy = $signed(trig.c[1]);
    assign sz = $signed(trig.s[2]);
    assign cz = $signed(trig.c[2]);

    function automatic logic [COMPONENT_BITS-1:0] to_comp(input logic signed [SW-1:0] a,
                                                          input logic signed [SW-1:0] b,
                                                          input logic sub);
        logic signed [ZW-1:0] s;
        logic signed [ZW-1:0] r;
        s = sub ? (ZW'(a) - ZW'(b)) : (ZW'(a) + ZW'(b));
        r = (s + RND) >>> SH;
        if (r > HI) r = HI;
        if (r < LO) r = LO;
        return r[COMPONENT_BITS-1:0];
    endfunction

    always_comb begin
        quat_next[0*COMPONENT_BITS +: COMPONENT_BITS] = to_comp(t_reg[0], t_reg[1], 1'b0);
        quat_next[1*COMPONENT_BITS +: COMPONENT_BITS] = to_comp(t_reg[2], t_reg[3], 1'b1);
        quat_next[2*COMPONENT_BITS +: COMPONENT_BITS] = to_comp(t_reg[4], t_reg[5], 1'b0);
        quat_next[3*COMPONENT_BITS +: COMPONENT_BITS] = to_comp(t_reg[6], t_reg[7], 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (enable) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            p_reg    <= qmul(cy, cz);
            q_reg    <= qmul(sy, sz);
            cxsy_reg <= qmul(cx, sy);
            sxcy_reg <= qmul(sx, cy);
            cxcy_reg <= qmul(cx, cy);
            sxsy_reg <= qmul(sx, sy);
            cx1_reg  <= cx;
            sx1_reg  <= sx;
            cz1_reg  <= cz;
            sz1_reg  <= sz;
            t_reg[0] <= qmul(cx1_reg, p_reg);
            t_reg[1] <= qmul(sx1_reg, q_reg);
            t_reg[2] <= qmul(sx1_reg, p_reg);
            t_reg[3] <= qmul(cx1_reg, q_reg);
            t_reg[4] <= qmul(cxsy_reg, cz1_reg);
            t_reg[5] <= qmul(sxcy_reg, sz1_reg);
            t_reg[6] <= qmul(cxcy_reg, sz1_reg);
            t_reg[7] <= qmul(sxsy_reg, cz1_reg);
            quat_reg <= quat_next;
        end
    end

    assign out_valid = v3_reg;
    assign quat      = quat_reg;

endmodule

// File: hw/rtl/euler_to_quaternion.sv
`timescale 1ns / 1ps
// Euler angles (x, y, z) to unit quaternion: angle pipeline, CORDIC chain, products.
// Depends on eq_pkg, eq_cordic_stage and eq_quat_mult.
//
// Channel   Dir  Payload
// s_axis    in   tdata: roll_angle, pitch_angle, yaw_angle (ANGLE_BITS each)
// m_axis    out  tdata: quat_w, quat_x, quat_y, quat_z (COMPONENT_BITS each)
//
// One transfer accepted per cycle while m_axis is not stalled. Data passes the reduction
// stage, the one-step-per-stage CORDIC chain, then sign, two multiply and output stages.
// Synchronous active-low reset clears all valid bits.
// A stall on m_axis holds every stage; nothing is dropped or repeated.
module euler_to_quaternion #(
    parameter int ANGLE_BITS     = 16,
    parameter int COMPONENT_BITS = 16,
    parameter int CORDIC_STEPS   = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // roll_angle, pitch_angle, yaw_angle, zero fill
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, zero fill
    output logic [((4*COMPONENT_BITS+7)/8)*8-1:0]  m_axis_tdata
);
    import eq_pkg::*;

    localparam int OUT_W = ((4*COMPONENT_BITS+7)/8)*8;

    logic    enable;
    cordic_t red_next;
    logic    chain_valid [CORDIC_STEPS+1];
    cordic_t chain_data  [CORDIC_STEPS+1];
    logic    trig_valid_reg;
    trig_t   trig_reg;
    trig_t   trig_next;
    logic    out_valid;
    logic [4*COMPONENT_BITS-1:0] quat;
    logic    red_valid_reg;
    cordic_t red_reg;

    assign enable        = !out_valid || m_axis_tready;
    assign s_axis_tready = enable;

    always_comb begin
        logic signed [ANGLE_BITS-1:0] a;
        logic signed [ZW-1:0]         h;
        red_next = '0;
        for (int k = 0; k < 3; k++) begin
            a = $signed(s_axis_tdata[k*ANGLE_BITS +: ANGLE_BITS]);
            h = ZW'(a) <<< (33 - ANGLE_BITS);
            red_next.flip[k] = 1'b0;
            if (h > HALF_PI_Q30) begin
                h = h - PI_Q30;
                red_next.flip[k] = 1'b1;
            end else if (h < -HALF_PI_Q30) begin
                h = h + PI_Q30;
                red_next.flip[k] = 1'b1;
            end
            red_next.lane[k].x = GAIN_Q30;
            red_next.lane[k].y = '0;
            red_next.lane[k].z = h;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_valid_reg  <= 1'b0;
            trig_valid_reg <= 1'b0;
        end else if (enable) begin
            red_valid_reg  <= s_axis_tvalid;
            trig_valid_reg <= chain_valid[CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            red_reg  <= red_next;
            trig_reg <= trig_next;
        end
    end

    assign chain_valid[0] = red_valid_reg;
    assign chain_data[0]  = red_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        eq_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .enable    (enable),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    always_comb begin
        logic signed [XW-1:0] cv;
        logic signed [XW-1:0] sv;
        trig_next = '0;
        for (int k = 0; k < 3; k++) begin
            cv = chain_data[CORDIC_STEPS].lane[k].x;
            sv = chain_data[CORDIC_STEPS].lane[k].y;
            if (chain_data[CORDIC_STEPS].flip[k]) begin
                cv = -cv;
                sv = -sv;
            end
            trig_next.c[k] = cv[SW-1:0];
            trig_next.s[k] = sv[SW-1:0];
        end
    end

    eq_quat_mult #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (enable),
        .in_valid  (trig_valid_reg),
        .trig      (trig_reg),
        .out_valid (out_valid),
        .quat      (quat)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = OUT_W'(quat);

`ifndef SYNTHESIS
    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid set after reset");

    a_stall_holds_sign_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(trig_reg) && $stable(trig_valid_reg)))
        else $error("sign stage moved during stall");

    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (red_valid_reg && !s_axis_tready) |=> $stable(red_reg))
        else $error("reduction stage moved while input stalled");
`endif

endmodule
